// File: rtl/smc_pkg.sv
// Shared types, constants and a helper function of the soil moisture conditioner.
`timescale 1ns / 1ps

package smc_pkg;

   // Field widths
   localparam int ADC_BITS       = 12;
   localparam int COUNT_BITS     = 32;
   localparam int PCT_BITS       = 7;
   localparam int HUND_BITS      = 14;
   localparam int BIN_BITS       = 2;
   localparam int RAW_SUM_BITS   = 44;
   localparam int MOIST_SUM_BITS = 46;
   localparam int NUM_BITS       = ADC_BITS + HUND_BITS;
   localparam int STEP_BITS      = $clog2(HUND_BITS);
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = ADC_BITS;

   // Scaling constants
   localparam logic [HUND_BITS-1:0] FULL_SCALE = HUND_BITS'(10000);
   localparam logic [HUND_BITS-1:0] PCT_SCALE  = HUND_BITS'(100);

   // Bin codes
   localparam logic [BIN_BITS-1:0] BIN_ONE   = BIN_BITS'(1);
   localparam logic [BIN_BITS-1:0] BIN_TWO   = BIN_BITS'(2);
   localparam logic [BIN_BITS-1:0] BIN_THREE = BIN_BITS'(3);

   // Opcodes of an input item
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WET_LEVEL = 3'd0,
      CSR_DRY_LEVEL = 3'd1,
      CSR_BIN_ONE   = 3'd2,
      CSR_BIN_TWO   = 3'd3,
      CSR_BIN_THREE = 3'd4
   } csr_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      SMC_IDLE,
      SMC_DIVIDE,
      SMC_FINISH
   } state_type;

   // Input item
   typedef struct packed {
      logic                opcode;
      logic [ADC_BITS-1:0] adc_sample;
   } req_type;

   // Result item
   typedef struct packed {
      logic                      sample_ok;
      logic [HUND_BITS-1:0]      moisture_hundredths;
      logic [BIN_BITS-1:0]       bin_index;
      logic [ADC_BITS-1:0]       min_seen;
      logic [ADC_BITS-1:0]       max_seen;
      logic [RAW_SUM_BITS-1:0]   raw_total;
      logic [MOIST_SUM_BITS-1:0] moisture_total;
      logic [COUNT_BITS-1:0]     sample_total;
   } rsp_type;

   // Divider command
   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] numerator;
      logic [ADC_BITS-1:0] divisor;
   } div_ctrl_type;

   // Divider status
   typedef struct packed {
      logic                 done;
      logic [HUND_BITS-1:0] quotient;
   } div_status_type;

   // Distance between a moisture value and a bin level given in percent
   function automatic logic [HUND_BITS-1:0] bin_distance(
      input logic [HUND_BITS-1:0] moist,
      input logic [PCT_BITS-1:0]  pct
   );
      logic [HUND_BITS-1:0] level;
      level = HUND_BITS'(HUND_BITS'(pct) * PCT_SCALE);
      return (moist >= level) ? HUND_BITS'(moist - level) : HUND_BITS'(level - moist);
   endfunction

endpackage

// File: rtl/soil_moisture_conditioner.sv
// Top level of the soil moisture conditioner: sequencer, statistics and result register.
`timescale 1ns / 1ps

// Converts one 12-bit probe sample at a time into moisture in hundredths of a
// percent, (dry - raw) * 10000 / (dry - wet) truncated and clamped to 0..10000,
// snaps it to the nearest of three bin levels (ties to the lower bin) and keeps
// min, max, raw sum, moisture sum and a saturating count. A sample that needs
// the division goes through the divide state and waits there for the 14 steps
// of the shared subtract-and-compare divider; a clear, a zero sample or a
// sample whose result is fixed by the calibration span goes straight to finish.
// req_stall is high while an item is in work; the result sits in an output
// register, so the next item is taken while rsp_stall holds the previous one.
// Configuration writes are always ready and must only be made while idle.
module soil_moisture_conditioner (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  smc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output smc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [smc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [smc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers
   logic [smc_pkg::ADC_BITS-1:0] wet_ff, dry_ff;
   logic [smc_pkg::PCT_BITS-1:0] bin1_ff, bin2_ff, bin3_ff;

   // Sequencer and item registers
   smc_pkg::state_type            state_ff, state_in;
   logic                          op_ff, op_in;
   logic [smc_pkg::ADC_BITS-1:0]  raw_ff, raw_in;
   logic [smc_pkg::HUND_BITS-1:0] moist_ff, moist_in;

   // Statistics
   logic [smc_pkg::ADC_BITS-1:0]       low_ff, low_in;
   logic [smc_pkg::ADC_BITS-1:0]       high_ff, high_in;
   logic [smc_pkg::RAW_SUM_BITS-1:0]   raw_sum_ff, raw_sum_in;
   logic [smc_pkg::MOIST_SUM_BITS-1:0] moist_sum_ff, moist_sum_in;
   logic [smc_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [smc_pkg::BIN_BITS-1:0]       last_bin_ff, last_bin_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   smc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Divider link
   smc_pkg::div_ctrl_type   div_ctrl;
   smc_pkg::div_status_type div_status;

   // Calibration terms of the incoming sample
   logic [smc_pkg::ADC_BITS-1:0]  span;
   logic [smc_pkg::ADC_BITS-1:0]  diff;
   logic [smc_pkg::NUM_BITS-1:0]  scaled;
   logic                          calib_ok;

   // Bin search on the held moisture value
   logic [smc_pkg::HUND_BITS-1:0] dist1, dist2, dist3, best_dist;
   logic [smc_pkg::BIN_BITS-1:0]  best_bin;

   assign span     = dry_ff - wet_ff;
   assign diff     = dry_ff - req_data.adc_sample;
   assign scaled   = smc_pkg::NUM_BITS'(diff) * smc_pkg::NUM_BITS'(smc_pkg::FULL_SCALE);
   assign calib_ok = (dry_ff > wet_ff) && (req_data.adc_sample < dry_ff);

   // Pick the nearest bin, keep the lower one on a tie
   always_comb begin
      dist1     = smc_pkg::bin_distance(moist_ff, bin1_ff);
      dist2     = smc_pkg::bin_distance(moist_ff, bin2_ff);
      dist3     = smc_pkg::bin_distance(moist_ff, bin3_ff);
      best_bin  = smc_pkg::BIN_ONE;
      best_dist = dist1;
      if (dist2 < best_dist) begin
         best_bin  = smc_pkg::BIN_TWO;
         best_dist = dist2;
      end
      if (dist3 < best_dist) begin
         best_bin = smc_pkg::BIN_THREE;
      end
   end

   smc_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .div_ctrl   (div_ctrl),
      .div_status (div_status)
   );

   // Sequence one item: take it, divide if needed, then update and post the result
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      raw_in           = raw_ff;
      moist_in         = moist_ff;
      low_in           = low_ff;
      high_in          = high_ff;
      raw_sum_in       = raw_sum_ff;
      moist_sum_in     = moist_sum_ff;
      count_in         = count_ff;
      last_bin_in      = last_bin_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_in      = rsp_data_ff;
      div_ctrl.start     = 1'b0;
      div_ctrl.numerator = scaled;
      div_ctrl.divisor   = span;
      unique case (state_ff)
         smc_pkg::SMC_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.opcode;
               raw_in   = req_data.adc_sample;
               moist_in = '0;
               state_in = smc_pkg::SMC_FINISH;
               if ((req_data.opcode == smc_pkg::OP_SAMPLE) && (req_data.adc_sample != '0)
                   && calib_ok) begin
                  // Below the wet level the quotient always overshoots full scale
                  if (req_data.adc_sample < wet_ff) begin
                     moist_in = smc_pkg::FULL_SCALE;
                  end else begin
                     div_ctrl.start = 1'b1;
                     state_in       = smc_pkg::SMC_DIVIDE;
                  end
               end
            end
         end
         smc_pkg::SMC_DIVIDE: begin
            if (div_status.done) begin
               moist_in = div_status.quotient;
               state_in = smc_pkg::SMC_FINISH;
            end
         end
         smc_pkg::SMC_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.sample_ok           = 1'b0;
               rsp_data_in.moisture_hundredths = '0;
               if (op_ff == smc_pkg::OP_CLEAR) begin
                  low_in       = '1;
                  high_in      = '0;
                  raw_sum_in   = '0;
                  moist_sum_in = '0;
                  count_in     = '0;
                  last_bin_in  = smc_pkg::BIN_ONE;
                  rsp_data_in.bin_index = smc_pkg::BIN_ONE;
               end else if (raw_ff == '0) begin
                  rsp_data_in.bin_index = last_bin_ff;
               end else begin
                  last_bin_in = best_bin;
                  if (raw_ff < low_ff) begin
                     low_in = raw_ff;
                  end
                  if (raw_ff > high_ff) begin
                     high_in = raw_ff;
                  end
                  // Freeze the sums once the count saturates
                  if (count_ff != '1) begin
                     raw_sum_in   = raw_sum_ff + smc_pkg::RAW_SUM_BITS'(raw_ff);
                     moist_sum_in = moist_sum_ff + smc_pkg::MOIST_SUM_BITS'(moist_ff);
                     count_in     = count_ff + smc_pkg::COUNT_BITS'(1);
                  end
                  rsp_data_in.sample_ok           = 1'b1;
                  rsp_data_in.moisture_hundredths = moist_ff;
                  rsp_data_in.bin_index           = best_bin;
               end
               rsp_data_in.min_seen       = low_in;
               rsp_data_in.max_seen       = high_in;
               rsp_data_in.raw_total      = raw_sum_in;
               rsp_data_in.moisture_total = moist_sum_in;
               rsp_data_in.sample_total   = count_in;
               rsp_valid_in = 1'b1;
               state_in     = smc_pkg::SMC_IDLE;
            end
         end
         default: begin
            state_in = smc_pkg::SMC_IDLE;
         end
      endcase
   end

   // Control and statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smc_pkg::SMC_IDLE;
         rsp_valid_ff <= 1'b0;
         low_ff       <= '1;
         high_ff      <= '0;
         raw_sum_ff   <= '0;
         moist_sum_ff <= '0;
         count_ff     <= '0;
         last_bin_ff  <= smc_pkg::BIN_ONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         raw_sum_ff   <= raw_sum_in;
         moist_sum_ff <= moist_sum_in;
         count_ff     <= count_in;
         last_bin_ff  <= last_bin_in;
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      raw_ff      <= raw_in;
      moist_ff    <= moist_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Write configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         wet_ff  <= smc_pkg::ADC_BITS'(280);
         dry_ff  <= smc_pkg::ADC_BITS'(650);
         bin1_ff <= smc_pkg::PCT_BITS'(20);
         bin2_ff <= smc_pkg::PCT_BITS'(40);
         bin3_ff <= smc_pkg::PCT_BITS'(60);
      end else if (csr_valid) begin
         unique case (csr_index)
            smc_pkg::CSR_WET_LEVEL: wet_ff  <= csr_wdata[smc_pkg::ADC_BITS-1:0];
            smc_pkg::CSR_DRY_LEVEL: dry_ff  <= csr_wdata[smc_pkg::ADC_BITS-1:0];
            smc_pkg::CSR_BIN_ONE:   bin1_ff <= csr_wdata[smc_pkg::PCT_BITS-1:0];
            smc_pkg::CSR_BIN_TWO:   bin2_ff <= csr_wdata[smc_pkg::PCT_BITS-1:0];
            smc_pkg::CSR_BIN_THREE: bin3_ff <= csr_wdata[smc_pkg::PCT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != smc_pkg::SMC_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Moisture never leaves the clamped range
   a_moist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.moisture_hundredths <= smc_pkg::FULL_SCALE))
      else $error("moisture beyond full scale");

   // Empty statistics carry empty sums
   a_empty_sums: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> ((raw_sum_ff == '0) && (moist_sum_ff == '0)))
      else $error("sums not empty with zero count");

   // Once any sample counted, min never exceeds max
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (low_ff <= high_ff))
      else $error("min above max");

   // The divider only reports while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == smc_pkg::SMC_DIVIDE))
      else $error("divider done outside divide state");

endmodule

// File: rtl/smc_divider.sv
// Iterative restoring divider: one shared subtract and compare per cycle.
`timescale 1ns / 1ps

module smc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  smc_pkg::div_ctrl_type   div_ctrl,
   output smc_pkg::div_status_type div_status
);

   logic [smc_pkg::NUM_BITS-1:0]  rem_ff, rem_in;
   logic [smc_pkg::NUM_BITS-1:0]  dsh_ff, dsh_in;
   logic [smc_pkg::HUND_BITS-1:0] quo_ff, quo_in;
   logic [smc_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          fits;

   // Compare the partial remainder with the shifted divisor
   assign fits = (rem_ff >= dsh_ff);

   // Load on start, then retire one quotient bit a cycle, most significant first
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctrl.start) begin
         rem_in  = div_ctrl.numerator;
         dsh_in  = smc_pkg::NUM_BITS'(div_ctrl.divisor) << (smc_pkg::HUND_BITS - 1);
         quo_in  = '0;
         step_in = smc_pkg::STEP_BITS'(smc_pkg::HUND_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[smc_pkg::HUND_BITS-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - smc_pkg::STEP_BITS'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign div_status.done     = done_ff;
   assign div_status.quotient = quo_ff;

endmodule

// File: tb/sv/smc_checker.sv
// Checker for the soil moisture conditioner: watches all channels, predicts and compares results.
`timescale 1ns / 1ps

module smc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  smc_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  smc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [smc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [smc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);

   import smc_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_CEILING = '1;
   localparam logic [ADC_BITS-1:0]   WET_AT_RESET  = ADC_BITS'(280);
   localparam logic [ADC_BITS-1:0]   DRY_AT_RESET  = ADC_BITS'(650);
   localparam logic [PCT_BITS-1:0]   BIN1_AT_RESET = PCT_BITS'(20);
   localparam logic [PCT_BITS-1:0]   BIN2_AT_RESET = PCT_BITS'(40);
   localparam logic [PCT_BITS-1:0]   BIN3_AT_RESET = PCT_BITS'(60);

   // Calibration copy
   logic [ADC_BITS-1:0]       wet_lvl;
   logic [ADC_BITS-1:0]       dry_lvl;
   logic [PCT_BITS-1:0]       bin1_pct;
   logic [PCT_BITS-1:0]       bin2_pct;
   logic [PCT_BITS-1:0]       bin3_pct;

   // Statistics copy
   logic [ADC_BITS-1:0]       lowest_raw;
   logic [ADC_BITS-1:0]       highest_raw;
   logic [RAW_SUM_BITS-1:0]   raw_acc;
   logic [MOIST_SUM_BITS-1:0] moist_acc;
   logic [COUNT_BITS-1:0]     valid_samples;
   logic [BIN_BITS-1:0]       prev_bin;

   rsp_type                   expected_rsp [$];
   int                        mismatches = 0;

   function automatic void clear_stats();
      lowest_raw    = '1;
      highest_raw   = '0;
      raw_acc       = '0;
      moist_acc     = '0;
      valid_samples = '0;
      prev_bin      = BIN_ONE;
   endfunction

   // Two-point calibration, truncated and clamped to full scale
   function automatic logic [HUND_BITS-1:0] calibrate(input logic [ADC_BITS-1:0] raw);
      logic [63:0] quot;
      if (dry_lvl <= wet_lvl || raw >= dry_lvl)
         return '0;
      quot = (64'(dry_lvl - raw) * 64'd10000) / 64'(dry_lvl - wet_lvl);
      return (quot > 64'd10000) ? FULL_SCALE : quot[HUND_BITS-1:0];
   endfunction

   function automatic int unsigned pct_gap(input logic [HUND_BITS-1:0] moist,
                                           input logic [PCT_BITS-1:0]  pct);
      int unsigned level;
      level = 32'(pct) * 32'd100;
      return (moist >= level) ? moist - level : level - moist;
   endfunction

   // Nearest bin; a later bin wins only on a strictly smaller gap
   function automatic logic [BIN_BITS-1:0] snap_bin(input logic [HUND_BITS-1:0] moist);
      logic [BIN_BITS-1:0] best;
      int unsigned         best_gap;
      int unsigned         gap;
      best     = BIN_ONE;
      best_gap = pct_gap(moist, bin1_pct);
      gap = pct_gap(moist, bin2_pct);
      if (gap < best_gap) begin
         best     = BIN_TWO;
         best_gap = gap;
      end
      gap = pct_gap(moist, bin3_pct);
      if (gap < best_gap)
         best = BIN_THREE;
      return best;
   endfunction

   // Advance the statistics by one item and build its result
   function automatic rsp_type condition_item(input req_type it);
      rsp_type              res;
      logic                 ok;
      logic [HUND_BITS-1:0] moist;
      logic [BIN_BITS-1:0]  bin;
      ok    = 1'b0;
      moist = '0;
      if (it.opcode == OP_CLEAR) begin
         clear_stats();
         bin = BIN_ONE;
      end else if (it.adc_sample == '0) begin
         bin = prev_bin;
      end else begin
         ok       = 1'b1;
         moist    = calibrate(it.adc_sample);
         bin      = snap_bin(moist);
         prev_bin = bin;
         if (it.adc_sample < lowest_raw)
            lowest_raw = it.adc_sample;
         if (it.adc_sample > highest_raw)
            highest_raw = it.adc_sample;
         // Freeze the sums once the count is saturated
         if (valid_samples != COUNT_CEILING) begin
            raw_acc       = raw_acc + RAW_SUM_BITS'(it.adc_sample);
            moist_acc     = moist_acc + MOIST_SUM_BITS'(moist);
            valid_samples = valid_samples + 1'b1;
         end
      end
      res.sample_ok           = ok;
      res.moisture_hundredths = moist;
      res.bin_index           = bin;
      res.min_seen            = lowest_raw;
      res.max_seen            = highest_raw;
      res.raw_total           = raw_acc;
      res.moisture_total      = moist_acc;
      res.sample_total        = valid_samples;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Track configuration, queue predictions, compare results
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         wet_lvl  = WET_AT_RESET;
         dry_lvl  = DRY_AT_RESET;
         bin1_pct = BIN1_AT_RESET;
         bin2_pct = BIN2_AT_RESET;
         bin3_pct = BIN3_AT_RESET;
         clear_stats();
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WET_LEVEL: wet_lvl  = csr_wdata;
               CSR_DRY_LEVEL: dry_lvl  = csr_wdata;
               CSR_BIN_ONE:   bin1_pct = csr_wdata[PCT_BITS-1:0];
               CSR_BIN_TWO:   bin2_pct = csr_wdata[PCT_BITS-1:0];
               CSR_BIN_THREE: bin3_pct = csr_wdata[PCT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result item arrived with no item waiting");
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("sample_ok", want.sample_ok, rsp_data.sample_ok);
               check_field("moisture_hundredths", want.moisture_hundredths,
                           rsp_data.moisture_hundredths);
               check_field("bin_index", want.bin_index, rsp_data.bin_index);
               check_field("min_seen", want.min_seen, rsp_data.min_seen);
               check_field("max_seen", want.max_seen, rsp_data.max_seen);
               check_field("raw_total", want.raw_total, rsp_data.raw_total);
               check_field("moisture_total", want.moisture_total, rsp_data.moisture_total);
               check_field("sample_total", want.sample_total, rsp_data.sample_total);
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(condition_item(req_data));
      end
      outstanding <= expected_rsp.size();
      fail_count  <= mismatches;
   end

endmodule

// File: tb/sv/soil_moisture_conditioner_tb.sv
// Testbench top of the soil moisture conditioner: stimulus, idling, pressure and verdict.
`timescale 1ns / 1ps

module soil_moisture_conditioner_tb;

   import smc_pkg::*;

   localparam int RAND_PHASES     = 9;
   localparam int ITEMS_PER_PHASE = 104;
   localparam int PRESSURE_PHASE  = 6;
   localparam int HOLD_CYCLES     = 300;
   localparam int TAIL_CYCLES     = 24;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int                       fail_count;
   int                       outstanding;

   int                       send_idle_pct = 21;
   int                       recv_idle_pct = 82;
   logic                     pressure_on   = 1'b0;
   logic                     pressure_seen = 1'b0;
   int                       hold_left     = 0;

   // Calibration as last written, used to aim samples at the useful band
   logic [ADC_BITS-1:0]      cur_wet = ADC_BITS'(280);
   logic [ADC_BITS-1:0]      cur_dry = ADC_BITS'(650);

   soil_moisture_conditioner u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   smc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off when pressure is requested
   always @(posedge clock) begin
      if (pressure_on && !pressure_seen) begin
         pressure_seen <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_stall     <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic req_type mk_item(input opcode_type op, input int unsigned sample);
      req_type it;
      it.opcode     = op;
      it.adc_sample = ADC_BITS'(sample);
      return it;
   endfunction

   // Mostly samples, many in or near the wet..dry band, some zeros and clears
   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      pick          = $urandom_range(99);
      it.opcode     = OP_SAMPLE;
      it.adc_sample = ADC_BITS'($urandom_range(4095, 1));
      if (pick < 3) begin
         it.opcode     = OP_CLEAR;
         it.adc_sample = ADC_BITS'($urandom);
      end else if (pick < 8) begin
         it.adc_sample = '0;
      end else if (pick >= 45 && cur_wet < cur_dry) begin
         lo = (cur_wet > 20) ? cur_wet - 20 : 1;
         hi = (cur_dry < 4075) ? cur_dry + 20 : 4095;
         it.adc_sample = ADC_BITS'($urandom_range(hi, lo));
      end
      return it;
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input req_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0]  idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_calibration(input int unsigned wet, input int unsigned dry,
                                  input int unsigned b1, input int unsigned b2,
                                  input int unsigned b3);
      drain();
      write_reg(CSR_WET_LEVEL, CSR_DATA_BITS'(wet));
      write_reg(CSR_DRY_LEVEL, CSR_DATA_BITS'(dry));
      write_reg(CSR_BIN_ONE,   CSR_DATA_BITS'(b1));
      write_reg(CSR_BIN_TWO,   CSR_DATA_BITS'(b2));
      write_reg(CSR_BIN_THREE, CSR_DATA_BITS'(b3));
      csr_valid <= 1'b0;
      cur_wet = ADC_BITS'(wet);
      cur_dry = ADC_BITS'(dry);
   endtask

   // Random bin level, with the unused upper data bits set at random
   function automatic int unsigned random_bin_word();
      return ($urandom_range(31) << PCT_BITS) | $urandom_range(127);
   endfunction

   initial begin
      int unsigned wet;
      int unsigned dry;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset calibration, no samples yet, zero samples, range ends
      send_item(mk_item(OP_SAMPLE, 0));
      send_item(mk_item(OP_SAMPLE, 4095));
      send_item(mk_item(OP_SAMPLE, 0));
      send_item(mk_item(OP_SAMPLE, 1));
      send_item(mk_item(OP_SAMPLE, 0));
      send_item(mk_item(OP_SAMPLE, 650));
      send_item(mk_item(OP_SAMPLE, 280));
      send_item(mk_item(OP_SAMPLE, 465));
      send_item(mk_item(OP_CLEAR, 4095));
      send_item(mk_item(OP_SAMPLE, 0));

      // A tie between neighboring bins, then samples near the range ends
      set_calibration(1000, 2000, 20, 40, 60);
      send_item(mk_item(OP_SAMPLE, 1700));
      send_item(mk_item(OP_SAMPLE, 1999));
      send_item(mk_item(OP_SAMPLE, 1001));

      // Zero and negative span
      set_calibration(2000, 2000, 20, 40, 60);
      send_item(mk_item(OP_SAMPLE, 1000));
      set_calibration(4095, 0, 20, 40, 60);
      send_item(mk_item(OP_SAMPLE, 2048));

      // Unused register indexes must change nothing
      drain();
      for (int i = CSR_BIN_THREE + 1; i < (1 << CSR_IDX_BITS); i++)
         write_reg(CSR_IDX_BITS'(i), CSR_DATA_BITS'($urandom));
      csr_valid <= 1'b0;
      send_item(mk_item(OP_SAMPLE, 2048));

      // Full scale, equal bins and bins above one hundred percent
      set_calibration(0, 4095, 127, 127, 127);
      send_item(mk_item(OP_SAMPLE, 1));
      send_item(mk_item(OP_SAMPLE, 4094));
      set_calibration(0, 4095, 0, 100, 127);
      send_item(mk_item(OP_SAMPLE, 4095));
      send_item(mk_item(OP_SAMPLE, 2048));
      send_item(mk_item(OP_SAMPLE, 2047));
      send_item(mk_item(OP_CLEAR, 0));
      send_item(mk_item(OP_SAMPLE, 3000));
      set_calibration(0, 4095, 100, 50, 0);
      send_item(mk_item(OP_SAMPLE, 1));

      // Random phases: three idling regimes, calibration changed per phase
      for (int p = 0; p < RAND_PHASES; p++) begin
         send_idle_pct = (p < 3) ? 21 : ((p < 6) ? 82 : 0);
         recv_idle_pct = (p < 3) ? 82 : ((p < 6) ? 21 : 0);
         case (p)
            0: set_calibration(0, 4095, 0, 50, 100);
            3: set_calibration(4095, 0, 127, 0, 127);
            default: begin
               wet = $urandom_range(3000);
               dry = wet + $urandom_range(4095 - wet, 1);
               if ($urandom_range(9) == 0)
                  dry = $urandom_range(wet);
               set_calibration(wet, dry, random_bin_word(), random_bin_word(),
                               random_bin_word());
            end
         endcase
         if (p == PRESSURE_PHASE)
            pressure_on <= 1'b1;
         repeat (ITEMS_PER_PHASE) send_item(random_item());
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
rtl/smc_pkg.sv
rtl/smc_divider.sv
rtl/soil_moisture_conditioner.sv
tb/sv/smc_checker.sv
tb/sv/soil_moisture_conditioner_tb.sv
